// ===== hw/rtl/u8d_pkg.sv =====
package u8d_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned CpW = 21;
  localparam int unsigned CntW = 32;
  localparam int unsigned OutDataW = 96;

  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_CONT  = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4,
    CLS_BAD   = 3'd5,
    CLS_END   = 3'd6
  } byte_class_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LEAD  = 2'd1,
    ST_BAD_CONT  = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_e;

  typedef struct packed {
    byte_class_e cls;
    logic [7:0]  data;
  } q_entry_t;

  function automatic byte_class_e classify(logic [7:0] b, logic last);
    byte_class_e c;
    if (last) begin
      c = CLS_END;
    end else if (b <= 8'h7f) begin
      c = CLS_ASCII;
    end else if (b <= 8'hbf) begin
      c = CLS_CONT;
    end else if (b <= 8'hdf) begin
      c = CLS_LEAD2;
    end else if (b <= 8'hef) begin
      c = CLS_LEAD3;
    end else if (b <= 8'hf7) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_BAD;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// Streaming UTF-8 decoder. Each request carries one byte in tdata, or an end of stream
// when tlast is high, in which case the byte is ignored and any pending sequence is
// reported as truncated. Lead bytes up to 0xF7 start sequences of two to four bytes, and
// one result is sent per finished character or per error, with byte offset and character
// index counters that wrap at 2^32. The block takes one request per clock cycle while the
// queue is not full: a front stage classifies the byte into a small queue, and the decode
// stage drains it at one entry per cycle into a registered output unless that output holds
// a result not yet taken. Output stalls backpressure the input once the queue fills.
module utf8_stream_decoder_unit
  import u8d_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // data_byte[7:0]
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // code_point[20:0], status[22:21], seq_length[25:23], start_offset[57:26],
  // char_index[89:58], zero[95:90]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic     q_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_wr_entry;
  q_entry_t q_rd_entry;

  u8d_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_wr_entry)
  );

  u8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry)
  );

  u8d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_rd_entry),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> q_valid)
    else $error("accepted request did not reach the queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[22:21] != ST_OK)) |-> (m_axis_tdata_o[20:0] == '0))
    else $error("error result carries a nonzero code point");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[22:21] == ST_OK))
      |-> ((m_axis_tdata_o[25:23] != 3'd0) && (m_axis_tdata_o[25:23] <= 3'd4)))
    else $error("valid character with impossible sequence length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[22:21] == ST_TRUNCATED))
      |-> ((m_axis_tdata_o[25:23] != 3'd0) && (m_axis_tdata_o[25:23] <= 3'd3)))
    else $error("truncated sequence with impossible length");

endmodule

// ===== hw/rtl/u8d_front.sv =====
module u8d_front
  import u8d_pkg::*;
(
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       s_axis_tlast_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output q_entry_t   q_entry_o
);

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    q_entry_o.cls  = classify(s_axis_tdata_i, s_axis_tlast_i);
    q_entry_o.data = s_axis_tdata_i;
  end

endmodule

// ===== hw/rtl/u8d_queue.sv =====
module u8d_queue
  import u8d_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output q_entry_t entry_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  q_entry_t          mem_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;

  assign full_o  = (count_q == CountW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CountW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/u8d_back.sv =====
module u8d_back
  import u8d_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  q_entry_t            q_entry_i,
  output logic                q_pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [CpW-1:0]  acc_q, acc_d;
  logic [1:0]      rem_q, rem_d;
  logic [2:0]      len_q, len_d;
  logic [CntW-1:0] byte_cnt_q, byte_cnt_d;
  logic [CntW-1:0] char_cnt_q, char_cnt_d;
  logic [CntW-1:0] start_q, start_d;

  logic            out_valid_q, out_valid_d;
  logic [CpW-1:0]  out_cp_q;
  status_e         out_st_q;
  logic [2:0]      out_len_q;
  logic [CntW-1:0] out_start_q;
  logic [CntW-1:0] out_char_q;

  logic            emit;
  logic [CpW-1:0]  emit_cp;
  status_e         emit_st;
  logic [2:0]      emit_len;
  logic [CntW-1:0] emit_start;
  logic [CpW-1:0]  acc_shift;

  assign q_pop_o   = q_valid_i && (!out_valid_q || m_axis_tready_i);
  assign acc_shift = {acc_q[CpW-7:0], q_entry_i.data[5:0]};

  always_comb begin
    acc_d      = acc_q;
    rem_d      = rem_q;
    len_d      = len_q;
    byte_cnt_d = byte_cnt_q;
    char_cnt_d = char_cnt_q;
    start_d    = start_q;
    emit       = 1'b0;
    emit_cp    = '0;
    emit_st    = ST_OK;
    emit_len   = 3'd1;
    emit_start = byte_cnt_q;

    if (q_pop_o) begin
      if (q_entry_i.cls == CLS_END) begin
        if (rem_q != 2'd0) begin
          emit       = 1'b1;
          emit_st    = ST_TRUNCATED;
          emit_len   = len_q - {1'b0, rem_q};
          emit_start = start_q;
          acc_d      = '0;
          rem_d      = 2'd0;
          len_d      = 3'd0;
        end
      end else begin
        byte_cnt_d = byte_cnt_q + CntW'(1);
        if (rem_q != 2'd0) begin
          emit_start = start_q;
          if (q_entry_i.cls != CLS_CONT) begin
            emit     = 1'b1;
            emit_st  = ST_BAD_CONT;
            emit_len = len_q - {1'b0, rem_q} + 3'd1;
            acc_d    = '0;
            rem_d    = 2'd0;
            len_d    = 3'd0;
          end else if (rem_q == 2'd1) begin
            emit       = 1'b1;
            emit_cp    = acc_shift;
            emit_len   = len_q;
            char_cnt_d = char_cnt_q + CntW'(1);
            acc_d      = '0;
            rem_d      = 2'd0;
            len_d      = 3'd0;
          end else begin
            acc_d = acc_shift;
            rem_d = rem_q - 2'd1;
          end
        end else begin
          case (q_entry_i.cls)
            CLS_ASCII: begin
              emit       = 1'b1;
              emit_cp    = CpW'(q_entry_i.data[6:0]);
              char_cnt_d = char_cnt_q + CntW'(1);
            end
            CLS_LEAD2: begin
              start_d = byte_cnt_q;
              acc_d   = CpW'(q_entry_i.data & 8'h1f);
              rem_d   = 2'd1;
              len_d   = 3'd2;
            end
            CLS_LEAD3: begin
              start_d = byte_cnt_q;
              acc_d   = CpW'(q_entry_i.data & 8'h0f);
              rem_d   = 2'd2;
              len_d   = 3'd3;
            end
            CLS_LEAD4: begin
              start_d = byte_cnt_q;
              acc_d   = CpW'(q_entry_i.data & 8'h07);
              rem_d   = 2'd3;
              len_d   = 3'd4;
            end
            default: begin
              emit    = 1'b1;
              emit_st = ST_BAD_LEAD;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = emit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      rem_q       <= 2'd0;
      len_q       <= 3'd0;
      byte_cnt_q  <= '0;
      char_cnt_q  <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      len_q       <= len_d;
      byte_cnt_q  <= byte_cnt_d;
      char_cnt_q  <= char_cnt_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      out_cp_q    <= emit_cp;
      out_st_q    <= emit_st;
      out_len_q   <= emit_len;
      out_start_q <= emit_start;
      out_char_q  <= char_cnt_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_char_q, out_start_q, out_len_q, out_st_q, out_cp_q};

endmodule
